// ----- rtl/core/hss_pkg.sv -----
package hss_pkg;

  // Run modes
  typedef enum logic [1:0] {
    MODE_STOPPED    = 2'd0,
    MODE_FINITE     = 2'd1,
    MODE_CONTINUOUS = 2'd2
  } run_mode_t;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_MOVE = 2'd1,
    OP_RUN  = 2'd2,
    OP_STOP = 2'd3
  } opcode_t;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_TARGET_INTERVAL = 2'd0;
  localparam logic [1:0] REG_START_INTERVAL  = 2'd1;
  localparam logic [1:0] REG_ACCEL_STEP      = 2'd2;

  // Reset values
  localparam logic [15:0] TARGET_INTERVAL_RST = 16'd2000;
  localparam logic [15:0] START_INTERVAL_RST  = 16'd2000;
  localparam logic [7:0]  ACCEL_STEP_RST      = 8'd2;
  localparam logic [15:0] INTERVAL_RST        = 16'd2000;

  // Phase advance per half-step
  localparam logic [2:0] PHASE_FWD = 3'd1;
  localparam logic [2:0] PHASE_BWD = 3'd7;

  // Half-step coil pattern, bit0 is IN1
  function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
    logic [3:0] pat;
    case (phase)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

// ----- rtl/core/half_step_stepper_sequencer.sv -----
// Channel   | Handshake                    | Payload
// ----------+------------------------------+------------------------------------
// request   | req_valid / req_stall        | opcode, dir_forward, step_count,
//           |                              | now_us
// result    | res_valid / res_stall        | coils, done_res, busy_res
// config    | APB psel/penable/pwrite      | paddr, pwdata, prdata, pready
//
// One request per cycle while req_stall is low; its result is registered and appears in the cycle after acceptance.
// The whole step decision is one pass of compare/subtract logic between the
// request edge and the state and result registers.
// A result is taken in the same cycle a new request may enter; req_stall is
// raised only while a result waits and res_stall is high.
// Reset (rst, synchronous) stops the motor, releases the coils and restores
// the register defaults.
module half_step_stepper_sequencer #(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  opcode,
  input  logic        dir_forward,
  input  logic [31:0] step_count,
  input  logic [31:0] now_us,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic [3:0]  coils,
  output logic        done_res,
  output logic        busy_res,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [15:0] target_interval;
  logic [15:0] start_interval;
  logic [7:0]  accel_step;

  // Motion state
  hss_pkg::run_mode_t    mode, mode_next;
  logic [2:0]            phase, phase_next;
  logic                  going_forward, going_forward_next;
  logic [31:0]           steps_left, steps_left_next;
  logic [TIME_WIDTH-1:0] last_step_time, last_step_time_next;
  logic [15:0]           cur_interval, cur_interval_next;
  logic [3:0]            coil_latch, coil_latch_next;
  logic                  done, done_next;

  logic                  accept;
  logic                  cfg_write;
  logic [63:0]           now_ext;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  step_due;
  logic [15:0]           start_iv;
  logic [15:0]           iv_diff;
  logic [15:0]           iv_cut;
  logic [2:0]            phase_step;

  assign accept    = req_valid && !req_stall;
  assign req_stall = res_valid && res_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Timestamp at the working width
  assign now_ext = {32'd0, now_us};
  assign now_t   = now_ext[TIME_WIDTH-1:0];
  assign elapsed = now_t - last_step_time;

  assign step_due = (mode != hss_pkg::MODE_STOPPED) &&
                    (elapsed >= TIME_WIDTH'(cur_interval));

  assign start_iv   = (target_interval < start_interval) ? start_interval : target_interval;
  assign iv_diff    = cur_interval - target_interval;
  assign iv_cut     = (iv_diff < {8'd0, accel_step}) ? iv_diff : {8'd0, accel_step};
  assign phase_step = going_forward ? hss_pkg::PHASE_FWD : hss_pkg::PHASE_BWD;

  // Work out the next motion state for one request
  always_comb begin
    mode_next           = mode;
    phase_next          = phase;
    going_forward_next  = going_forward;
    steps_left_next     = steps_left;
    last_step_time_next = last_step_time;
    cur_interval_next   = cur_interval;
    coil_latch_next     = coil_latch;
    done_next           = 1'b0;
    case (hss_pkg::opcode_t'(opcode))
      hss_pkg::OP_TICK: begin
        if (step_due) begin
          if (mode == hss_pkg::MODE_FINITE && steps_left == 32'd0) begin
            // release after the final hold interval
            mode_next       = hss_pkg::MODE_STOPPED;
            steps_left_next = 32'd0;
            coil_latch_next = 4'h0;
            done_next       = 1'b1;
          end else begin
            last_step_time_next = now_t;
            phase_next          = phase + phase_step;
            coil_latch_next     = hss_pkg::coil_pattern(phase + phase_step);
            if (mode == hss_pkg::MODE_FINITE) begin
              steps_left_next = steps_left - 32'd1;
            end
            if (cur_interval > target_interval) begin
              cur_interval_next = cur_interval - iv_cut;
            end
          end
        end
      end
      hss_pkg::OP_MOVE: begin
        if (step_count == 32'd0) begin
          mode_next       = hss_pkg::MODE_STOPPED;
          steps_left_next = 32'd0;
          coil_latch_next = 4'h0;
        end else begin
          steps_left_next     = step_count;
          going_forward_next  = dir_forward;
          mode_next           = hss_pkg::MODE_FINITE;
          cur_interval_next   = start_iv;
          last_step_time_next = now_t;
        end
      end
      hss_pkg::OP_RUN: begin
        steps_left_next     = 32'd0;
        going_forward_next  = dir_forward;
        mode_next           = hss_pkg::MODE_CONTINUOUS;
        cur_interval_next   = start_iv;
        last_step_time_next = now_t;
      end
      default: begin
        mode_next       = hss_pkg::MODE_STOPPED;
        steps_left_next = 32'd0;
        coil_latch_next = 4'h0;
      end
    endcase
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= hss_pkg::MODE_STOPPED;
      phase          <= 3'd0;
      going_forward  <= 1'b1;
      steps_left     <= 32'd0;
      last_step_time <= '0;
      cur_interval   <= hss_pkg::INTERVAL_RST;
      coil_latch     <= 4'h0;
      done           <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (accept) begin
        mode           <= mode_next;
        phase          <= phase_next;
        going_forward  <= going_forward_next;
        steps_left     <= steps_left_next;
        last_step_time <= last_step_time_next;
        cur_interval   <= cur_interval_next;
        coil_latch     <= coil_latch_next;
        done           <= done_next;
        res_valid      <= 1'b1;
      end else if (!res_stall) begin
        // drop the result once taken
        res_valid <= 1'b0;
      end
    end
  end

  assign coils    = coil_latch;
  assign done_res = done;
  assign busy_res = (mode != hss_pkg::MODE_STOPPED);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_interval <= hss_pkg::TARGET_INTERVAL_RST;
      start_interval  <= hss_pkg::START_INTERVAL_RST;
      accel_step      <= hss_pkg::ACCEL_STEP_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        hss_pkg::REG_TARGET_INTERVAL: target_interval <= pwdata[15:0];
        hss_pkg::REG_START_INTERVAL:  start_interval  <= pwdata[15:0];
        hss_pkg::REG_ACCEL_STEP:      accel_step      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Configuration reads
  always_comb begin
    case (paddr[3:2])
      hss_pkg::REG_TARGET_INTERVAL: prdata = {16'd0, target_interval};
      hss_pkg::REG_START_INTERVAL:  prdata = {16'd0, start_interval};
      hss_pkg::REG_ACCEL_STEP:      prdata = {24'd0, accel_step};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

// ----- tb/half_step_stepper_sequencer_tb.sv -----
`timescale 1ns / 1ps

module half_step_stepper_sequencer_tb;

  localparam int IDLE_LIMIT = 4000;
  localparam int SHOWN_MISMATCHES = 10;

  // Half-step coil patterns, entry 0 on the right
  localparam logic [7:0][3:0] HALF_STEP_COILS = {
    4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1
  };

  typedef struct packed {
    hss_pkg::opcode_t op;
    logic             fwd;
    logic [31:0]      count;
    logic [31:0]      stamp;
  } motor_req_t;

  typedef struct packed {
    logic [3:0] coils;
    logic       done;
    logic       busy;
  } coil_drive_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  opcode = hss_pkg::OP_TICK;
  logic        dir_forward = 1'b0;
  logic [31:0] step_count = 32'd0;
  logic [31:0] now_us = 32'd0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [3:0]  coils;
  logic        done_res;
  logic        busy_res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Register copies
  logic [15:0] cfg_target;
  logic [15:0] cfg_start;
  logic [7:0]  cfg_accel;

  // Motor state as the block should hold it
  hss_pkg::run_mode_t mtr_mode;
  logic [2:0]         mtr_phase;
  logic               mtr_fwd;
  logic [31:0]        mtr_left;
  logic [31:0]        mtr_last;
  logic [15:0]        mtr_interval;
  logic [3:0]         mtr_coils;

  motor_req_t  pending_q[$];
  coil_drive_t drive_expect_q[$];
  motor_req_t  cur_req;
  logic [31:0] clock_us;
  bit          calm = 1'b0;
  int          req_gap_left = 0;
  int          stall_left = 0;
  int          mismatch_count = 0;
  int          idle_cycles = 0;

  half_step_stepper_sequencer u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .opcode(opcode), .dir_forward(dir_forward), .step_count(step_count), .now_us(now_us),
    .res_valid(res_valid), .res_stall(res_stall),
    .coils(coils), .done_res(done_res), .busy_res(busy_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Drop the motor and release the coils
  task automatic release_coils();
    mtr_mode  = hss_pkg::MODE_STOPPED;
    mtr_left  = 32'd0;
    mtr_coils = 4'h0;
  endtask

  // Begin a move or run from the slower of the two intervals
  task automatic start_motion(input motor_req_t r, input hss_pkg::run_mode_t mode);
    mtr_fwd      = r.fwd;
    mtr_mode     = mode;
    mtr_interval = (cfg_target < cfg_start) ? cfg_start : cfg_target;
    mtr_last     = r.stamp;
  endtask

  // Apply one accepted request and queue the coil drive it should produce
  task automatic advance_motor(input motor_req_t r);
    coil_drive_t d;
    logic [31:0] elapsed;
    logic [15:0] slack;
    logic        released;
    released = 1'b0;
    case (r.op)
      hss_pkg::OP_TICK: begin
        if (mtr_mode != hss_pkg::MODE_STOPPED) begin
          elapsed = r.stamp - mtr_last;
          if (elapsed >= {16'd0, mtr_interval}) begin
            if (mtr_mode == hss_pkg::MODE_FINITE && mtr_left == 32'd0) begin
              release_coils();
              released = 1'b1;
            end else begin
              mtr_last  = r.stamp;
              mtr_phase = mtr_phase + (mtr_fwd ? hss_pkg::PHASE_FWD : hss_pkg::PHASE_BWD);
              mtr_coils = HALF_STEP_COILS[mtr_phase];
              if (mtr_mode == hss_pkg::MODE_FINITE) mtr_left = mtr_left - 32'd1;
              // ramp the interval down toward cruise
              if (mtr_interval > cfg_target) begin
                slack = mtr_interval - cfg_target;
                mtr_interval = mtr_interval -
                  ((slack < {8'd0, cfg_accel}) ? slack : {8'd0, cfg_accel});
              end
            end
          end
        end
      end
      hss_pkg::OP_MOVE: begin
        if (r.count == 32'd0) begin
          release_coils();
        end else begin
          mtr_left = r.count;
          start_motion(r, hss_pkg::MODE_FINITE);
        end
      end
      hss_pkg::OP_RUN: begin
        mtr_left = 32'd0;
        start_motion(r, hss_pkg::MODE_CONTINUOUS);
      end
      default: release_coils();
    endcase
    d.coils = mtr_coils;
    d.done  = released;
    d.busy  = (mtr_mode != hss_pkg::MODE_STOPPED);
    drive_expect_q.push_back(d);
  endtask

  task automatic push_req(input hss_pkg::opcode_t op, input logic fwd,
                          input logic [31:0] count, input logic [31:0] stamp);
    motor_req_t r;
    r.op    = op;
    r.fwd   = fwd;
    r.count = count;
    r.stamp = stamp;
    pending_q.push_back(r);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      hss_pkg::REG_TARGET_INTERVAL: cfg_target = data[15:0];
      hss_pkg::REG_START_INTERVAL:  cfg_start  = data[15:0];
      hss_pkg::REG_ACCEL_STEP:      cfg_accel  = data[7:0];
      default: ;
    endcase
  endtask

  // Junk in the unused upper bits must be ignored
  task automatic set_ramp(input logic [15:0] target, input logic [15:0] start,
                          input logic [7:0] accel);
    write_reg(hss_pkg::REG_TARGET_INTERVAL, ($urandom & 32'hFFFF0000) | {16'd0, target});
    write_reg(hss_pkg::REG_START_INTERVAL, ($urandom & 32'hFFFF0000) | {16'd0, start});
    write_reg(hss_pkg::REG_ACCEL_STEP, ($urandom & 32'hFFFFFF00) | {24'd0, accel});
  endtask

  // Hold until every request is through and its drive has come back
  task automatic wait_drained();
    @(negedge clk);
    while (pending_q.size() != 0 || req_valid || drive_expect_q.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly ticks paced near the interval, with some commands and noise
  task automatic queue_motion(input int n);
    motor_req_t r;
    int k;
    int pick;
    int span;
    logic [31:0] gap;
    @(negedge clk);
    span = (cfg_target < cfg_start) ? cfg_start : cfg_target;
    for (k = 0; k < n; k++) begin
      pick    = $urandom_range(0, 99);
      r.fwd   = 1'($urandom_range(0, 1));
      r.count = $urandom;
      if (pick < 7) begin
        r.op = hss_pkg::OP_MOVE;
        case ($urandom_range(0, 9))
          0:       r.count = 32'd0;
          1:       r.count = 32'hFFFFFFFF;
          2:       ;
          default: r.count = $urandom_range(1, 6);
        endcase
      end else if (pick < 10) begin
        r.op = hss_pkg::OP_RUN;
      end else if (pick < 13) begin
        r.op = hss_pkg::OP_STOP;
      end else begin
        r.op = hss_pkg::OP_TICK;
      end
      case ($urandom_range(0, 19))
        0:       gap = 32'd0;
        1:       gap = $urandom;
        2:       gap = span * 4 + 1;
        default: gap = $urandom_range(0, span + 1);
      endcase
      clock_us = clock_us + gap;
      r.stamp  = clock_us;
      pending_q.push_back(r);
    end
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_gap_left = 0;
    end else begin
      if (req_valid && !req_stall) advance_motor(cur_req);
      if (!req_valid || !req_stall) begin
        if (req_gap_left > 0) begin
          req_gap_left--;
          req_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          req_gap_left = $urandom_range(0, 9);
          req_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          cur_req = pending_q.pop_front();
          opcode      <= cur_req.op;
          dir_forward <= cur_req.fwd;
          step_count  <= cur_req.count;
          now_us      <= cur_req.stamp;
          req_valid   <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and stall bursts
  always @(posedge clk) begin
    coil_drive_t want;
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (drive_expect_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_MISMATCHES)
            $display("unexpected drive: coils=%h done=%b busy=%b", coils, done_res, busy_res);
        end else begin
          want = drive_expect_q.pop_front();
          if (coils !== want.coils || done_res !== want.done || busy_res !== want.busy) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_MISMATCHES)
              $display({"drive mismatch: expected coils=%h done=%b busy=%b, ",
                        "got coils=%h done=%b busy=%b"},
                       want.coils, want.done, want.busy, coils, done_res, busy_res);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 9);
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("half_step_stepper_sequencer_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int p;
    cfg_target   = hss_pkg::TARGET_INTERVAL_RST;
    cfg_start    = hss_pkg::START_INTERVAL_RST;
    cfg_accel    = hss_pkg::ACCEL_STEP_RST;
    mtr_mode     = hss_pkg::MODE_STOPPED;
    mtr_phase    = 3'd0;
    mtr_fwd      = 1'b1;
    mtr_left     = 32'd0;
    mtr_last     = 32'd0;
    mtr_interval = hss_pkg::INTERVAL_RST;
    mtr_coils    = 4'h0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part on reset registers
    @(negedge clk);
    push_req(hss_pkg::OP_TICK, 1'b1, 32'd0, 32'd0);              // tick while stopped
    push_req(hss_pkg::OP_STOP, 1'b0, 32'hFFFFFFFF, 32'd5);
    push_req(hss_pkg::OP_MOVE, 1'b0, 32'd0, 32'd7);     // zero-step move acts as stop
    push_req(hss_pkg::OP_MOVE, 1'b1, 32'd2, 32'd100);
    push_req(hss_pkg::OP_TICK, 1'b0, 32'd0, 32'd2099);  // one short of the interval
    push_req(hss_pkg::OP_TICK, 1'b0, 32'd0, 32'd2100);
    push_req(hss_pkg::OP_TICK, 1'b1, 32'd0, 32'd4100);
    push_req(hss_pkg::OP_TICK, 1'b1, 32'd0, 32'd6099);
    push_req(hss_pkg::OP_TICK, 1'b0, 32'd0, 32'd6100);  // hold expires, coils released
    push_req(hss_pkg::OP_TICK, 1'b1, 32'd0, 32'd9000);
    push_req(hss_pkg::OP_RUN, 1'b0, 32'hFFFFFFFF, 32'hFFFFF000);
    push_req(hss_pkg::OP_TICK, 1'b1, 32'd0, 32'h000003D0);       // timestamp wraps
    push_req(hss_pkg::OP_TICK, 1'b0, 32'd0, 32'h000189B0);       // late tick, single step
    push_req(hss_pkg::OP_TICK, 1'b0, 32'd0, 32'h000189B0);
    push_req(hss_pkg::OP_STOP, 1'b1, 32'd0, 32'h00020000);
    push_req(hss_pkg::OP_MOVE, 1'b1, 32'hFFFFFFFF, 32'h7FFFFFFF);
    push_req(hss_pkg::OP_TICK, 1'b0, 32'hFFFFFFFF, 32'h800007CF);
    push_req(hss_pkg::OP_MOVE, 1'b0, 32'd1, 32'h80000800);       // restart during a move
    push_req(hss_pkg::OP_TICK, 1'b1, 32'd0, 32'h80000FD0);
    push_req(hss_pkg::OP_TICK, 1'b1, 32'd0, 32'h800017A0);
    push_req(hss_pkg::OP_RUN, 1'b1, 32'h55555555, 32'hAAAAAAAA);
    push_req(hss_pkg::OP_TICK, 1'b0, 32'hAAAAAAAA, 32'hAAAAB27A);
    push_req(hss_pkg::OP_STOP, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    wait_drained();

    // Zero interval: a step on every tick
    set_ramp(16'd0, 16'd0, 8'd0);
    clock_us = $urandom;
    queue_motion(80);
    wait_drained();

    // Slowest intervals, largest acceleration
    set_ramp(16'hFFFF, 16'hFFFF, 8'hFF);
    clock_us = 32'hFFF00000;
    queue_motion(60);
    wait_drained();

    // Ramp from a slow start down to a fast cruise
    set_ramp(16'd5, 16'd60, 8'd7);
    clock_us = $urandom;
    queue_motion(100);
    wait_drained();

    // Start faster than cruise: motion begins at cruise
    set_ramp(16'd40, 16'd3, 8'hFF);
    clock_us = $urandom;
    queue_motion(80);
    wait_drained();

    // Long gentle ramp
    set_ramp(16'd8, 16'd255, 8'd1);
    clock_us = $urandom;
    queue_motion(80);
    wait_drained();

    for (p = 0; p < 3; p++) begin
      set_ramp(16'($urandom_range(0, 30)), 16'($urandom_range(0, 300)),
               8'($urandom_range(0, 255)));
      clock_us = $urandom;
      queue_motion(60);
      wait_drained();
    end

    // Closing stretch at full rate
    calm = 1'b1;
    set_ramp(16'd2, 16'd20, 8'd3);
    clock_us = $urandom;
    queue_motion(80);
    wait_drained();

    if (mismatch_count == 0 && drive_expect_q.size() == 0) begin
      $display("half_step_stepper_sequencer_tb passed");
    end else begin
      $display("half_step_stepper_sequencer_tb failed");
    end
    $finish;
  end

endmodule
